>>> hdl/sha_pkg.sv
// shared types, constants and functions for the sha-256 stream hasher
`default_nettype none
package sha_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned FILL_W      = 6;
  localparam int unsigned COUNT_W     = 61;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned ROUND_W     = 6;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PAD,
    ST_COMPRESS,
    ST_EMIT
  } sha_state_t;

  // control from the top level to the compression engine
  typedef struct packed {
    logic start;
  } comp_ctrl_t;

  typedef struct packed {
    logic done;
  } comp_stat_t;

  function automatic logic [31:0] round_const(input logic [ROUND_W-1:0] idx);
    logic [31:0] k;
    begin
      unique case (idx)
        6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
        6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
        6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
        6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h;
    begin
      unique case (idx)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

endpackage
`default_nettype wire

>>> hdl/sha256_stream_hasher_core.sv
// top level of the byte-serial sha-256 stream hasher
// Takes one message byte per beat into a 64-byte block memory; each full
// block runs 64 compression rounds, one per cycle, plus a load step and a chain
// update, during which no beat is taken. Finishing a message
// writes the padding one byte per cycle (up to a whole block, twice when the
// length does not fit), then sends eight digest beats, word 0 first.
// Byte throughput is set by the single round unit.
`default_nettype none
module sha256_stream_hasher_core
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic [1:0]  s_tuser,   // byte_present, end_of_message
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // digest_word
  output logic [2:0]       m_tuser,   // word_number
  output logic             m_tlast    // last_word
);

  sha_state_t  state, state_next;
  logic [FILL_W-1:0]  fill;
  logic [COUNT_W-1:0] count;
  logic [FILL_W:0]    pad_pos;
  logic        pad_second;   // length fits only in a second block
  logic        after_pad;    // compression belongs to padding
  logic        finishing;
  logic [2:0]  word_cnt;
  logic        accept;
  logic        we;
  logic [5:0]  waddr;
  logic [7:0]  wdata;
  logic [63:0] bitlen;
  comp_ctrl_t  cctrl;
  comp_stat_t  cstat;
  logic        reinit;

  sha_compress u_comp (
    .clk, .rst, .ctrl(cctrl), .byte_we(we), .byte_addr(waddr), .byte_data(wdata),
    .hash_sel(word_cnt), .hash_reinit(reinit), .hash_word(m_tdata), .stat(cstat)
  );

  assign accept   = s_tvalid && s_tready;
  assign bitlen   = {count, 3'b000};
  assign m_tuser  = word_cnt;
  assign m_tlast  = (word_cnt == 3'd7);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (accept && s_tuser[0] && s_tuser[1] && fill == 6'd63) state_next = ST_COMPRESS;
        else if (accept && s_tuser[1]) state_next = ST_PAD;
        else if (accept && s_tuser[0] && fill == 6'd63) state_next = ST_COMPRESS;
      end
      ST_PAD:      if (pad_pos == 7'd63) state_next = ST_COMPRESS;
      ST_COMPRESS: if (cstat.done) state_next = after_pad ? (pad_second ? ST_PAD : ST_EMIT)
                                                          : (finishing ? ST_PAD : ST_COLLECT);
      ST_EMIT:     if (m_tready && word_cnt == 3'd7) state_next = ST_COLLECT;
      default:     state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_COLLECT);
    m_tvalid = (state == ST_EMIT);
    cctrl.start = 1'b0;
    we = 1'b0; waddr = fill; wdata = s_tdata;
    reinit = (state == ST_EMIT) && m_tready && (word_cnt == 3'd7);
    unique case (state)
      ST_COLLECT: begin
        we = accept && s_tuser[0];
        cctrl.start = accept && s_tuser[0] && fill == 6'd63;
      end
      ST_PAD: begin
        we = 1'b1; waddr = pad_pos[5:0];
        if (pad_pos[5:0] == fill && !pad_second) wdata = PAD_BYTE;
        else if (pad_pos >= 7'd56 && (pad_second || fill < 6'd56))
          wdata = bitlen[{~pad_pos[2:0], 3'b111} -: 8];
        else wdata = 8'h00;
        cctrl.start = (pad_pos == 7'd63);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT; fill <= '0; count <= '0; pad_pos <= '0;
      pad_second <= 1'b0; after_pad <= 1'b0; finishing <= 1'b0; word_cnt <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_COLLECT: if (accept) begin
          if (s_tuser[0]) begin
            fill  <= fill + 1'b1;
            count <= count + 1'b1;
          end
          finishing <= s_tuser[1];
          after_pad <= 1'b0;
          pad_second <= 1'b0;
          // a full block wraps the position back to zero
          pad_pos <= {1'b0, (s_tuser[0] ? fill + 1'b1 : fill)};
        end
        ST_PAD: begin
          pad_pos <= pad_pos + 1'b1;
          if (pad_pos == 7'd63) begin
            after_pad <= 1'b1;
            // 0x80 at 56 or later leaves no room for the length
            if (!pad_second && fill >= 6'd56) pad_second <= 1'b1;
            else pad_second <= 1'b0;
          end
        end
        ST_COMPRESS: if (cstat.done) begin
          pad_pos <= (after_pad || finishing) ? '0 : {1'b0, fill};
          if (after_pad && pad_second) begin
            fill <= 6'd0;
            after_pad <= 1'b0;
          end
        end
        ST_EMIT: if (m_tready) begin
          word_cnt <= word_cnt + 1'b1;
          if (word_cnt == 3'd7) begin
            fill <= '0; count <= '0; finishing <= 1'b0;
            after_pad <= 1'b0; pad_second <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input taken while digest pending");
  a_emit_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cstat.done)) else $error("digest without compression");
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> word_cnt == 3'd0) else $error("digest starts mid-word");
`endif

endmodule
`default_nettype wire

>>> hdl/sha_compress.sv
// sha-256 compression engine: one round per cycle over a word-wide block memory
`default_nettype none
module sha_compress
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire comp_ctrl_t  ctrl,
  // block memory write port, byte wide, big-endian inside each word
  input  wire logic        byte_we,
  input  wire logic [5:0]  byte_addr,
  input  wire logic [7:0]  byte_data,
  input  wire logic [2:0]  hash_sel,
  input  wire logic        hash_reinit,
  output logic [31:0]      hash_word,
  output comp_stat_t       stat
);

  logic [31:0] blk_mem [16];
  logic [31:0] chain [8];
  logic [31:0] w [16];
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [ROUND_W:0] rnd;
  logic        running;
  logic        load;
  logic        done;
  logic [31:0] wt, s0, s1, ch, mj, bs0, bs1, x1, w_new;
  logic [3:0]  rd_idx;
  logic [31:0] rd_word;

  // byte lanes of the addressed word are merged in place
  always_ff @(posedge clk) begin
    if (byte_we) begin
      unique case (byte_addr[1:0])
        2'd0: blk_mem[byte_addr[5:2]][31:24] <= byte_data;
        2'd1: blk_mem[byte_addr[5:2]][23:16] <= byte_data;
        2'd2: blk_mem[byte_addr[5:2]][15:8]  <= byte_data;
        default: blk_mem[byte_addr[5:2]][7:0] <= byte_data;
      endcase
    end
    rd_word <= blk_mem[rd_idx];
  end

  // read address runs one ahead of the round counter while running
  assign rd_idx = rnd[3:0] + {3'b000, running};

  // word for this round: memory for the first sixteen, schedule after
  always_comb begin
    s0    = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1    = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    wt    = (rnd < ROUND_W'(16) + 7'd0) ? rd_word : w_new;
    bs1   = {ve[5:0], ve[31:6]} ^ {ve[10:0], ve[31:11]} ^ {ve[24:0], ve[31:25]};
    ch    = (ve & vf) ^ (~ve & vg);
    x1    = vh + bs1 + ch + round_const(rnd[ROUND_W-1:0]) + wt;
    bs0   = {va[1:0], va[31:2]} ^ {va[12:0], va[31:13]} ^ {va[21:0], va[31:22]};
    mj    = (va & vb) ^ (va & vc) ^ (vb & vc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      load    <= 1'b0;
      done    <= 1'b0;
      rnd     <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= init_hash(3'(i));
    end else begin
      done <= 1'b0;
      if (hash_reinit) begin
        for (int i = 0; i < 8; i++) chain[i] <= init_hash(3'(i));
      end
      if (ctrl.start && !running && !load) begin
        load <= 1'b1;
        rnd  <= '0;
        va <= chain[0]; vb <= chain[1]; vc <= chain[2]; vd <= chain[3];
        ve <= chain[4]; vf <= chain[5]; vg <= chain[6]; vh <= chain[7];
      end else if (load) begin
        // first memory read is now registered
        load    <= 1'b0;
        running <= 1'b1;
      end else if (running) begin
        vh <= vg; vg <= vf; vf <= ve; ve <= vd + x1;
        vd <= vc; vc <= vb; vb <= va; va <= x1 + bs0 + mj;
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wt;
        if (rnd == (ROUND_W+1)'(ROUNDS - 1)) begin
          running <= 1'b0;
        end
        rnd <= rnd + 1'b1;
      end else if (rnd == (ROUND_W+1)'(ROUNDS)) begin
        chain[0] <= chain[0] + va; chain[1] <= chain[1] + vb;
        chain[2] <= chain[2] + vc; chain[3] <= chain[3] + vd;
        chain[4] <= chain[4] + ve; chain[5] <= chain[5] + vf;
        chain[6] <= chain[6] + vg; chain[7] <= chain[7] + vh;
        rnd  <= '0;
        done <= 1'b1;
      end
    end
  end

  assign hash_word  = chain[hash_sel];
  assign stat.done  = done;

endmodule
`default_nettype wire

>>> bench/sha256_stream_hasher_core_tb.sv
// self-checking bench for the byte-serial sha-256 stream hasher
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_core_tb
  import sha_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        last;
  } digest_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
    logic       check_fixed;
    logic [31:0] fixed_w0;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  sha256_stream_hasher_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  blk [64];
  int unsigned blk_fill;
  logic [60:0] msg_len;

  digest_beat_t digest_q [$];
  logic [31:0]  w0_override_q [$];
  int unsigned  errors = 0;
  int unsigned  digests_seen = 0;
  int unsigned  items_sent = 0;
  int unsigned  cycles = 0;
  bit           rx_stall_mode;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = IV_TAB[i];
    blk_fill = 0;
    msg_len = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic predict_item(logic [7:0] data, logic present, logic eom);
    logic [63:0] bitlen;
    digest_beat_t b;
    if (present) begin
      blk[blk_fill] = data;
      blk_fill++;
      msg_len++;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end
    if (!eom) return;
    bitlen = {msg_len, 3'b000};
    blk[blk_fill] = PAD_BYTE;
    blk_fill++;
    if (blk_fill > 56) begin
      while (blk_fill < 64) blk[blk_fill++] = 8'h00;
      compress_block();
      blk_fill = 0;
    end
    while (blk_fill < 56) blk[blk_fill++] = 8'h00;
    for (int i = 0; i < 8; i++) blk[56+i] = bitlen[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      b.word = hash_state[i];
      b.num = 3'(i);
      b.last = (i == 7);
      digest_q = {digest_q, b};
    end
    restart_hash();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stalls: alternates between steady and choppy stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) rx_stall_mode <= ~rx_stall_mode;
    if (rst) m_tready <= 1'b0;
    else if (rx_stall_mode) m_tready <= ($urandom_range(0, 3) != 0);
    else m_tready <= ($urandom_range(0, 19) != 0);
  end

  always @(posedge clk) begin
    digest_beat_t exp_b;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected beat word=%h num=%0d last=%b", $time, m_tdata, m_tuser,
                 m_tlast);
        errors++;
      end else begin
        exp_b = digest_q.pop_front();
        if (exp_b.num == 0 && w0_override_q.size() != 0) begin
          if (w0_override_q[0] !== exp_b.word) begin
            $display("%0t: known digest word 0 expected %h, predictor %h", $time,
                     w0_override_q[0], exp_b.word);
            errors++;
          end
          void'(w0_override_q.pop_front());
        end
        if (m_tdata !== exp_b.word) begin
          $display("%0t: digest_word expected %h actual %h", $time, exp_b.word, m_tdata);
          errors++;
        end
        if (m_tuser !== exp_b.num) begin
          $display("%0t: word_number expected %0d actual %0d", $time, exp_b.num, m_tuser);
          errors++;
        end
        if (m_tlast !== exp_b.last) begin
          $display("%0t: last_word expected %b actual %b", $time, exp_b.last, m_tlast);
          errors++;
        end
        if (exp_b.last) digests_seen++;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats outstanding", $time, digest_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_beat(logic [7:0] data, logic present, logic eom);
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= {eom, present};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(data, present, eom);
    items_sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (n != 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      s_tuser <= 2'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // directed: empty message, "abc", idle items, byte extremes
  stim_row_t rows [10] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
    '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0}
  };
  int burst;
  int len;

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    rx_stall_mode = 1'b0;
    restart_hash();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].check_fixed) w0_override_q = {w0_override_q, rows[i].fixed_w0};
      send_beat(rows[i].data, rows[i].present, rows[i].eom);
    end
    s_tvalid <= 1'b0;

    // pause until the directed digests are all out
    while (digest_q.size() != 0) @(posedge clk);

    // random messages; lengths around the padding overflow point and one full block
    while (items_sent < 155) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(55, 57);
        1: len = $urandom_range(63, 65);
        2: len = 0;
        default: len = $urandom_range(1, 20);
      endcase
      burst = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
        send_beat(8'($urandom), 1'b1, 1'b0);
        burst--;
        if (burst == 0) begin
          idle_gap();
          burst = $urandom_range(1, 12);
        end
      end
      // end mark with or without a final byte
      if ($urandom_range(0, 1)) send_beat(8'($urandom), 1'b1, 1'b1);
      else send_beat(8'($urandom), 1'b0, 1'b1);
      idle_gap();
    end
    s_tvalid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("items sent: %0d, digests checked: %0d", items_sent, digests_seen);
    $display("covered empty and known messages, idle items, padding overflow and block edges");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
hdl/sha_pkg.sv
hdl/sha_compress.sv
hdl/sha256_stream_hasher_core.sv
bench/sha256_stream_hasher_core_tb.sv
